// ===== hdl/psd_pkg.sv =====
// ---------------------------------------------------------------------------
// psd_pkg
// shared constants and types for the point to segment distance block
// ---------------------------------------------------------------------------
package psd_pkg;

  // direction vector is signed q2.16
  localparam int DIR_FRAC  = 16;
  localparam int DIR_W     = DIR_FRAC + 2;

  // register index field, wide enough to address beyond the last register
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_Y   = 3'd3;

  typedef enum logic [2:0] {
    CS_DIFF,
    CS_SQUARE,
    CS_ROOT,
    CS_ROUND,
    CS_DIV,
    CS_SIGN,
    CS_DONE
  } cache_state_t;

endpackage

// ===== hdl/psd_point_if.sv =====
// ---------------------------------------------------------------------------
// psd_point_if
// query point channel: valid, ready and one point word
// ---------------------------------------------------------------------------
interface psd_point_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

// ===== hdl/psd_dist_if.sv =====
// ---------------------------------------------------------------------------
// psd_dist_if
// distance result channel: valid, ready and one distance word
// ---------------------------------------------------------------------------
interface psd_dist_if #(
  parameter int COORD_WIDTH = 24
);
  logic                 valid;
  logic                 ready;
  logic [COORD_WIDTH:0] distance;

  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

// ===== hdl/point_segment_distance.sv =====
// ---------------------------------------------------------------------------
// point_segment_distance
// streaming distance from query points to one configured line segment
// ---------------------------------------------------------------------------
//
//  channel  | dir | word                               | handshake
//  ---------+-----+------------------------------------+-----------------
//  in_ch    | in  | point_x, point_y  signed q16.8     | valid / ready
//  out_ch   | out | distance          unsigned q17.8   | valid / ready
//  cfg_*    | in  | cfg_index, cfg_wdata               | cfg_we, no wait
//
//  one word per cycle sustained while out_ch.ready is high and the length and
//  direction unit is done; COORD_WIDTH + 13 register stages, with a square
//  root pipeline of COORD_WIDTH + 3 stages
//  after reset and after each register write the length and direction unit
//  runs with in_ch.ready held low
//  each stage moves when its successor has room, so bubbles close up and a
//  stall on out_ch only holds words that cannot move
// ---------------------------------------------------------------------------
module point_segment_distance #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  psd_point_if.sink                           in_ch,
  psd_dist_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [psd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [COORD_WIDTH-1:0]              cfg_wdata
);
  import psd_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int UW  = W + 1;            // point minus start
  localparam int PW1 = UW + DIR_W;       // projection products
  localparam int TW  = W + 19;           // raw projection
  localparam int TCW = W + 17;           // clamped projection
  localparam int PW  = TCW + 1 + DIR_W;  // offset products
  localparam int EW  = W + 3;            // error vector
  localparam int SQW = 2 * EW - 2;
  localparam int SW2 = 2 * EW - 1;       // sum of squares
  localparam int NR  = EW;               // root bits, one stage each
  localparam int SQ0 = 9;                // first root stage
  localparam int NS  = SQ0 + NR + 1;

  // segment registers and cache
  logic signed [W-1:0]     sx_r, sy_r, ex_r, ey_r;
  logic                    restart;
  logic                    cache_done;
  logic [W:0]              seg_len;
  logic signed [DIR_W-1:0] dir_cos, dir_sin;

  always_comb begin
    restart = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_START_X, REG_START_Y, REG_END_X, REG_END_Y: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= '0;
      sy_r <= '0;
      ex_r <= '0;
      ey_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_X: sx_r <= cfg_wdata;
        REG_START_Y: sy_r <= cfg_wdata;
        REG_END_X:   ex_r <= cfg_wdata;
        REG_END_Y:   ey_r <= cfg_wdata;
        default: ;   // beyond the list: ignored
      endcase
    end
  end

  psd_cache #(.COORD_WIDTH(W)) u_cache (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (restart),
    .start_x (sx_r),
    .start_y (sy_r),
    .end_x   (ex_r),
    .end_y   (ey_r),
    .done    (cache_done),
    .seg_len (seg_len),
    .dir_cos (dir_cos),
    .dir_sin (dir_sin)
  );

  // stage control: a stage may load when it is empty or its successor loads
  logic [NS-1:0] v_r, en;
  logic          in_acc;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ch.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ch.ready = en[0] && cache_done;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_acc;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // data stages
  logic signed [W-1:0]   px0_r, py0_r;
  logic signed [UW-1:0]  ux1_r, uy1_r, ux2_r, uy2_r, ux3_r, uy3_r;
  logic signed [UW-1:0]  ux4_r, uy4_r, ux5_r, uy5_r;
  logic signed [PW1-1:0] pc2_r, ps2_r;
  logic [TCW-1:0]        tc3_r, tc_nxt;
  logic signed [TW-1:0]  t_nxt, lim_s;
  logic signed [PW-1:0]  ox4_r, oy4_r;
  logic [PW-1:0]         magx, magy, rndx, rndy;
  logic [EW-1:0]         rmx5_r, rmy5_r;
  logic                  sgx5_r, sgy5_r;
  logic signed [EW-1:0]  offx, offy, ex6_r, ey6_r;
  logic signed [2*EW-1:0] sqx_full, sqy_full;
  logic [SQW-1:0]        sqx7_r, sqy7_r;
  logic [SW2-1:0]        sum8_r;

  // projection, clamped to the segment
  assign t_nxt = TW'(pc2_r) + TW'(ps2_r);
  assign lim_s = $signed({2'b00, seg_len, {DIR_FRAC{1'b0}}});
  always_comb begin
    if (t_nxt[TW-1] || t_nxt == '0) tc_nxt = '0;
    else if (t_nxt >= lim_s)        tc_nxt = {seg_len, {DIR_FRAC{1'b0}}};
    else                            tc_nxt = t_nxt[TCW-1:0];
  end

  // offsets rounded to nearest, halves away from zero
  assign magx = ox4_r[PW-1] ? PW'(-ox4_r) : PW'(ox4_r);
  assign magy = oy4_r[PW-1] ? PW'(-oy4_r) : PW'(oy4_r);
  assign rndx = (magx + (PW'(1) << (2 * DIR_FRAC - 1))) >> (2 * DIR_FRAC);
  assign rndy = (magy + (PW'(1) << (2 * DIR_FRAC - 1))) >> (2 * DIR_FRAC);

  assign offx = sgx5_r ? -$signed(rmx5_r) : $signed(rmx5_r);
  assign offy = sgy5_r ? -$signed(rmy5_r) : $signed(rmy5_r);

  assign sqx_full = ex6_r * ex6_r;
  assign sqy_full = ey6_r * ey6_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      px0_r <= in_ch.point_x;
      py0_r <= in_ch.point_y;
    end
    if (en[1]) begin
      ux1_r <= UW'(px0_r) - UW'(sx_r);
      uy1_r <= UW'(py0_r) - UW'(sy_r);
    end
    if (en[2]) begin
      pc2_r <= ux1_r * dir_cos;
      ps2_r <= uy1_r * dir_sin;
      ux2_r <= ux1_r;
      uy2_r <= uy1_r;
    end
    if (en[3]) begin
      tc3_r <= tc_nxt;
      ux3_r <= ux2_r;
      uy3_r <= uy2_r;
    end
    if (en[4]) begin
      ox4_r <= $signed({1'b0, tc3_r}) * dir_cos;
      oy4_r <= $signed({1'b0, tc3_r}) * dir_sin;
      ux4_r <= ux3_r;
      uy4_r <= uy3_r;
    end
    if (en[5]) begin
      rmx5_r <= rndx[EW-1:0];
      rmy5_r <= rndy[EW-1:0];
      sgx5_r <= ox4_r[PW-1];
      sgy5_r <= oy4_r[PW-1];
      ux5_r  <= ux4_r;
      uy5_r  <= uy4_r;
    end
    if (en[6]) begin
      ex6_r <= EW'(ux5_r) - offx;
      ey6_r <= EW'(uy5_r) - offy;
    end
    if (en[7]) begin
      sqx7_r <= sqx_full[SQW-1:0];
      sqy7_r <= sqy_full[SQW-1:0];
    end
    if (en[8]) begin
      sum8_r <= SW2'(sqx7_r) + SW2'(sqy7_r);
    end
  end

  // square root, one root bit per stage
  logic [SW2-1:0] xs_r [NR];
  logic [SW2-1:0] rs_r [NR];
  logic [SW2-1:0] xs_nxt [NR];
  logic [SW2-1:0] rs_nxt [NR];

  always_comb begin
    logic [SW2-1:0] x_in, r_in, bitk, trial;
    for (int k = 0; k < NR; k++) begin
      x_in  = (k == 0) ? sum8_r : xs_r[(k == 0) ? 0 : k - 1];
      r_in  = (k == 0) ? '0     : rs_r[(k == 0) ? 0 : k - 1];
      bitk  = SW2'(1) << (2 * (NR - 1 - k));
      trial = r_in + bitk;
      if (x_in >= trial) begin
        xs_nxt[k] = x_in - trial;
        rs_nxt[k] = (r_in >> 1) + bitk;
      end else begin
        xs_nxt[k] = x_in;
        rs_nxt[k] = r_in >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NR; k++) begin
      if (en[SQ0+k]) begin
        xs_r[k] <= xs_nxt[k];
        rs_r[k] <= rs_nxt[k];
      end
    end
  end

  // rounding up past the half and saturation into the output register
  logic [SW2-1:0] dfull;
  logic [W:0]     dist_r;

  assign dfull = (xs_r[NR-1] > rs_r[NR-1]) ? rs_r[NR-1] + SW2'(1) : rs_r[NR-1];

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      dist_r <= (dfull > SW2'({(W+1){1'b1}})) ? {(W+1){1'b1}} : dfull[W:0];
    end
  end

  assign out_ch.valid    = v_r[NS-1];
  assign out_ch.distance = dist_r;

endmodule

// ===== hdl/psd_cache.sv =====
// ---------------------------------------------------------------------------
// psd_cache
// iterative unit for segment length and unit direction
// ---------------------------------------------------------------------------
module psd_cache #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  restart,
  input  logic signed [COORD_WIDTH-1:0]         start_x,
  input  logic signed [COORD_WIDTH-1:0]         start_y,
  input  logic signed [COORD_WIDTH-1:0]         end_x,
  input  logic signed [COORD_WIDTH-1:0]         end_y,
  output logic                                  done,
  output logic [COORD_WIDTH:0]                  seg_len,
  output logic signed [psd_pkg::DIR_W-1:0]      dir_cos,
  output logic signed [psd_pkg::DIR_W-1:0]      dir_sin
);
  import psd_pkg::*;

  localparam int W       = COORD_WIDTH;
  localparam int SW      = 2 * W + 2;
  localparam int NW      = W + 19;
  localparam int QW      = DIR_FRAC + 2;
  localparam int CNT_MAX = (W > QW - 1) ? W : QW - 1;
  localparam int CNTW    = $clog2(CNT_MAX + 1);

  cache_state_t state_r, state_nxt;
  logic [CNTW-1:0]     cnt_r;
  logic signed [W:0]   dx, dy;
  logic [W:0]          magx_r, magy_r, bx_r, by_r;
  logic                negx_r, negy_r;
  logic [SW-1:0]       mx_r, my_r, acc_r, r_r, bit_r, trial, rnd;
  logic [W:0]          len_r, len_nxt;
  logic [NW-1:0]       numx_r, numy_r, den_r;
  logic [QW-1:0]       qx_r, qy_r, qcx, qcy;
  logic signed [DIR_W-1:0] cos_r, sin_r;

  assign dx    = (W+1)'(end_x) - (W+1)'(start_x);
  assign dy    = (W+1)'(end_y) - (W+1)'(start_y);
  assign trial = r_r + bit_r;
  assign rnd   = (acc_r > r_r) ? r_r + SW'(1) : r_r;
  assign len_nxt = rnd[W:0];
  assign qcx = (qx_r > (QW'(1) << DIR_FRAC)) ? (QW'(1) << DIR_FRAC) : qx_r;
  assign qcy = (qy_r > (QW'(1) << DIR_FRAC)) ? (QW'(1) << DIR_FRAC) : qy_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_DIFF:   state_nxt = CS_SQUARE;
      CS_SQUARE: if (cnt_r == '0) state_nxt = CS_ROOT;
      CS_ROOT:   if (cnt_r == '0) state_nxt = CS_ROUND;
      CS_ROUND:  state_nxt = CS_DIV;
      CS_DIV:    if (cnt_r == '0) state_nxt = CS_SIGN;
      CS_SIGN:   state_nxt = CS_DONE;
      CS_DONE:   state_nxt = CS_DONE;
      default:   state_nxt = CS_DIFF;
    endcase
    if (restart) state_nxt = CS_DIFF;
  end

  // outputs
  always_comb begin
    done = (state_r == CS_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_DIFF;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      CS_DIFF: begin
        negx_r <= dx[W];
        negy_r <= dy[W];
        magx_r <= dx[W] ? (W+1)'(-dx) : dx;
        magy_r <= dy[W] ? (W+1)'(-dy) : dy;
        bx_r   <= dx[W] ? (W+1)'(-dx) : dx;
        by_r   <= dy[W] ? (W+1)'(-dy) : dy;
        mx_r   <= SW'(dx[W] ? (W+1)'(-dx) : dx);
        my_r   <= SW'(dy[W] ? (W+1)'(-dy) : dy);
        acc_r  <= '0;
        cnt_r  <= CNTW'(W);
      end
      CS_SQUARE: begin
        // shift and add, both squares at once
        acc_r <= acc_r + (bx_r[0] ? mx_r : '0) + (by_r[0] ? my_r : '0);
        mx_r  <= mx_r << 1;
        my_r  <= my_r << 1;
        bx_r  <= bx_r >> 1;
        by_r  <= by_r >> 1;
        if (cnt_r == '0) begin
          r_r   <= '0;
          bit_r <= SW'(1) << (2 * W);
          cnt_r <= CNTW'(W);
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
      CS_ROOT: begin
        if (acc_r >= trial) begin
          acc_r <= acc_r - trial;
          r_r   <= (r_r >> 1) + bit_r;
        end else begin
          r_r   <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 1'b1;
      end
      CS_ROUND: begin
        len_r  <= len_nxt;
        numx_r <= (NW'(magx_r) << DIR_FRAC) + NW'(len_nxt >> 1);
        numy_r <= (NW'(magy_r) << DIR_FRAC) + NW'(len_nxt >> 1);
        den_r  <= NW'(len_nxt) << (QW - 1);
        qx_r   <= '0;
        qy_r   <= '0;
        cnt_r  <= CNTW'(QW - 1);
      end
      CS_DIV: begin
        // restoring division, one quotient bit per cycle
        if (numx_r >= den_r) numx_r <= numx_r - den_r;
        if (numy_r >= den_r) numy_r <= numy_r - den_r;
        qx_r  <= {qx_r[QW-2:0], numx_r >= den_r};
        qy_r  <= {qy_r[QW-2:0], numy_r >= den_r};
        den_r <= den_r >> 1;
        cnt_r <= cnt_r - 1'b1;
      end
      CS_SIGN: begin
        if (len_r == '0) begin
          cos_r <= '0;
          sin_r <= '0;
        end else begin
          cos_r <= negx_r ? -$signed(qcx) : $signed(qcx);
          sin_r <= negy_r ? -$signed(qcy) : $signed(qcy);
        end
      end
      default: ;
    endcase
  end

  assign seg_len = len_r;
  assign dir_cos = cos_r;
  assign dir_sin = sin_r;

endmodule
